// File: hw/rtl/msp_pkg.sv
// Shared constants, types and a helper function for the mecanum wheel speed controller.
`default_nettype none

package msp_pkg;

   localparam int WHEEL_COUNT = 4;
   localparam int WHEEL_W     = $clog2(WHEEL_COUNT);
   localparam int VAL_W       = 16;
   localparam int GAIN_W      = 16;
   localparam int DUTY_W      = 14;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 3;

   localparam int QUEUE_DEPTH_DEF = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_LOOPS     = 3'd5;

   // Per-wheel signs of the kinematics and the forward level of each direction pin.
   localparam logic [WHEEL_COUNT-1:0] VX_NEG   = 4'b0101;
   localparam logic [WHEEL_COUNT-1:0] TURN_NEG = 4'b0110;
   localparam logic [WHEEL_COUNT-1:0] DIR_FWD  = 4'b0011;

   typedef logic signed [VAL_W-1:0] val_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [GAIN_W-1:0] deriv_gain;
      logic [GAIN_W-1:0] rotation_gain;
      logic [DUTY_W-1:0] duty_limit;
      logic              run_loops;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      prop_gain:     16'd11520,
      integ_gain:    16'd1408,
      deriv_gain:    16'd0,
      rotation_gain: 16'd12386,
      duty_limit:    14'd8000,
      run_loops:     1'b0
   };

   // One queued item: the speed error of every wheel.
   typedef logic [WHEEL_COUNT-1:0][VAL_W-1:0] entry_type;

   localparam logic signed [31:0] VAL_MAX = (32'sd1 <<< (VAL_W - 1)) - 32'sd1;
   localparam logic signed [31:0] VAL_MIN = -(32'sd1 <<< (VAL_W - 1));

   // Saturates a signed value to the range of a speed value.
   function automatic val_type sat_val(input logic signed [31:0] v);
      val_type r;
      if (v > VAL_MAX) begin
         r = VAL_MAX[VAL_W-1:0];
      end else if (v < VAL_MIN) begin
         r = VAL_MIN[VAL_W-1:0];
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/msp_if.sv
// Valid/ready channel interfaces for the command items and the duty result items.
`default_nettype none

interface msp_req_if;
   import msp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] vel_x;
   logic signed [VAL_W-1:0] vel_y;
   logic signed [VAL_W-1:0] turn_rate;
   logic signed [VAL_W-1:0] encoder_0;
   logic signed [VAL_W-1:0] encoder_1;
   logic signed [VAL_W-1:0] encoder_2;
   logic signed [VAL_W-1:0] encoder_3;

   modport source (
      output valid, vel_x, vel_y, turn_rate, encoder_0, encoder_1, encoder_2, encoder_3,
      input  ready
   );
   modport sink (
      input  valid, vel_x, vel_y, turn_rate, encoder_0, encoder_1, encoder_2, encoder_3,
      output ready
   );
endinterface

interface msp_rsp_if;
   import msp_pkg::*;

   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty_0;
   logic [DUTY_W-1:0] duty_1;
   logic [DUTY_W-1:0] duty_2;
   logic [DUTY_W-1:0] duty_3;
   logic              dir_0;
   logic              dir_1;
   logic              dir_2;
   logic              dir_3;

   modport source (
      output valid, duty_0, duty_1, duty_2, duty_3, dir_0, dir_1, dir_2, dir_3,
      input  ready
   );
   modport sink (
      input  valid, duty_0, duty_1, duty_2, duty_3, dir_0, dir_1, dir_2, dir_3,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/mecanum_wheel_speed_pid.sv
// Top level of the mecanum wheel speed controller: registers, front end, queue and PID engine.
//
// Each item on req_ch is one control tick: a body velocity command (vel_x, vel_y, turn_rate)
// and the four measured wheel speeds. While run_loops is set, the tick produces exactly
// one item on rsp_ch with four duty magnitudes and four direction pin levels. While it is
// clear, ticks are taken and dropped, and the wheel loops keep their state.
// The front end works out the four wheel errors after taking an item, one wheel at a time,
// and hands them to the PID engine through a small queue (QUEUE_DEPTH entries).
// The PID engine handles one wheel at a time on its single shared multiplier, and takes
// a new item from the queue only once the result of the last one is in the output register.
// The front end takes new items while the engine works, until the queue is full.
// A finished result sits in an output register; the engine may complete the next item behind
// it, and stops only when that second result is ready and the receiver still stalls.
// Configuration is a write-only register port (csr_we, csr_index, csr_wdata), to be written
// only while no item is in flight. Writes to unknown indexes are ignored.
// Synchronous reset restores the default gains and limit, disables the loops, clears all
// drive values and error history, and empties the queue and the output register.
`default_nettype none

module mecanum_wheel_speed_pid #(
   parameter int QUEUE_DEPTH = msp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   msp_req_if.sink                            req_ch,
   msp_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_we,
   input  wire logic [msp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [msp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import msp_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      q_push_valid, q_push_ready;
   entry_type q_push_data;
   logic      q_pop_valid, q_pop_ready;
   entry_type q_pop_data;

   // Register file: each write replaces one field of the configuration.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PROP_GAIN:     cfg_in.prop_gain     = csr_wdata[GAIN_W-1:0];
            CSR_INTEG_GAIN:    cfg_in.integ_gain    = csr_wdata[GAIN_W-1:0];
            CSR_DERIV_GAIN:    cfg_in.deriv_gain    = csr_wdata[GAIN_W-1:0];
            CSR_ROTATION_GAIN: cfg_in.rotation_gain = csr_wdata[GAIN_W-1:0];
            CSR_DUTY_LIMIT:    cfg_in.duty_limit    = csr_wdata[DUTY_W-1:0];
            CSR_RUN_LOOPS:     cfg_in.run_loops     = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .push_valid (q_push_valid),
      .push_data  (q_push_data),
      .push_ready (q_push_ready)
   );

   msp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_data  (q_push_data),
      .push_ready (q_push_ready),
      .pop_valid  (q_pop_valid),
      .pop_data   (q_pop_data),
      .pop_ready  (q_pop_ready)
   );

   msp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (q_pop_valid),
      .pop_data  (q_pop_data),
      .pop_ready (q_pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// File: hw/rtl/msp_front.sv
// Front end: takes command items, drops them while disabled, and computes the wheel errors.
`default_nettype none

module msp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire msp_pkg::cfg_type cfg,
   msp_req_if.sink               req_ch,
   output logic                  push_valid,
   output msp_pkg::entry_type    push_data,
   input  wire logic             push_ready
);
   import msp_pkg::*;

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_MUL  = 3'd1;
   localparam logic [2:0] F_SUM  = 3'd2;
   localparam logic [2:0] F_TRN  = 3'd3;
   localparam logic [2:0] F_ERR  = 3'd4;
   localparam logic [2:0] F_PUSH = 3'd5;

   localparam int TURN_W = 2 * VAL_W;
   localparam int BASE_W = VAL_W + 2;
   localparam int SUM_W  = TURN_W + 4;
   localparam int QUO_W  = SUM_W - VAL_W;

   logic [2:0]               state_ff, state_in;
   logic [WHEEL_W-1:0]       wheel_ff, wheel_in;
   val_type                  vx_ff, vy_ff, wr_ff;
   val_type                  enc_ff [WHEEL_COUNT];
   logic signed [TURN_W-1:0] turn_ff, turn_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   val_type                  tgt_ff, tgt_in;
   entry_type                err_ff;
   val_type                  err_in;

   logic                     accept;
   logic signed [BASE_W-1:0] vx_term, base;
   logic signed [SUM_W-1:0]  turn_term, biased;
   logic signed [QUO_W-1:0]  quo;
   logic signed [VAL_W:0]    diff;
   val_type                  enc_sel;
   logic                     last_wheel;

   assign req_ch.ready = (state_ff == F_IDLE);
   assign accept       = req_ch.valid & req_ch.ready;
   assign push_valid   = (state_ff == F_PUSH);
   assign push_data    = err_ff;
   assign last_wheel   = (wheel_ff == WHEEL_W'(WHEEL_COUNT - 1));

   // Kinematics of one wheel: exact Q20.16 sum, truncated toward zero, saturated.
   always_comb begin
      turn_in   = TURN_W'(wr_ff) * TURN_W'($signed({1'b0, cfg.rotation_gain}));
      vx_term   = VX_NEG[wheel_ff] ? -BASE_W'(vx_ff) : BASE_W'(vx_ff);
      base      = BASE_W'(vy_ff) + vx_term;
      turn_term = TURN_NEG[wheel_ff] ? -SUM_W'(turn_ff) : SUM_W'(turn_ff);
      sum_in    = (SUM_W'(base) <<< VAL_W) + turn_term;
      biased    = sum_ff + $signed({{(SUM_W - VAL_W){1'b0}}, {VAL_W{sum_ff[SUM_W-1]}}});
      quo       = biased[SUM_W-1:VAL_W];
      tgt_in    = sat_val(32'(quo));
      enc_sel   = enc_ff[wheel_ff];
      diff      = (VAL_W + 1)'(tgt_ff) - (VAL_W + 1)'(enc_sel);
      err_in    = sat_val(32'(diff));
   end

   always_comb begin
      state_in = state_ff;
      wheel_in = wheel_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept && cfg.run_loops) begin
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            state_in = F_SUM;
            wheel_in = '0;
         end
         F_SUM: begin
            state_in = F_TRN;
         end
         F_TRN: begin
            state_in = F_ERR;
         end
         F_ERR: begin
            if (last_wheel) begin
               state_in = F_PUSH;
            end else begin
               wheel_in = wheel_ff + 1'b1;
               state_in = F_SUM;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         wheel_ff <= '0;
      end else begin
         state_ff <= state_in;
         wheel_ff <= wheel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && accept) begin
         vx_ff     <= req_ch.vel_x;
         vy_ff     <= req_ch.vel_y;
         wr_ff     <= req_ch.turn_rate;
         enc_ff[0] <= req_ch.encoder_0;
         enc_ff[1] <= req_ch.encoder_1;
         enc_ff[2] <= req_ch.encoder_2;
         enc_ff[3] <= req_ch.encoder_3;
      end
      if (state_ff == F_MUL) begin
         turn_ff <= turn_in;
      end
      if (state_ff == F_SUM) begin
         sum_ff <= sum_in;
      end
      if (state_ff == F_TRN) begin
         tgt_ff <= tgt_in;
      end
      if (state_ff == F_ERR) begin
         err_ff[wheel_ff] <= err_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/msp_fifo.sv
// Small register queue of wheel error sets between the front end and the PID engine.
`default_nettype none

module msp_fifo #(
   parameter int DEPTH = msp_pkg::QUEUE_DEPTH_DEF   // two or more
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire msp_pkg::entry_type push_data,
   output logic                    push_ready,
   output logic                    pop_valid,
   output msp_pkg::entry_type      pop_data,
   input  wire logic               pop_ready
);
   import msp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   entry_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/msp_back.sv
// PID engine: runs the incremental PID of each wheel on one shared multiplier.
`default_nettype none

module msp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire msp_pkg::cfg_type   cfg,
   input  wire logic               pop_valid,
   input  wire msp_pkg::entry_type pop_data,
   output logic                    pop_ready,
   msp_rsp_if.source               rsp_ch
);
   import msp_pkg::*;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_INT   = 3'd1;
   localparam logic [2:0] B_PROP  = 3'd2;
   localparam logic [2:0] B_DERIV = 3'd3;
   localparam logic [2:0] B_SUM   = 3'd4;
   localparam logic [2:0] B_UPD   = 3'd5;
   localparam logic [2:0] B_DONE  = 3'd6;

   localparam int DRV_W  = DUTY_W + 1;
   localparam int D1_W   = VAL_W + 1;
   localparam int D2_W   = VAL_W + 3;
   localparam int PROD_W = GAIN_W + 1 + D2_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int FRAC_W = 8;
   localparam int QUO_W  = ACC_W - FRAC_W;

   logic [2:0]               state_ff, state_in;
   logic [WHEEL_W-1:0]       wheel_ff, wheel_in;
   entry_type                entry_ff;
   logic signed [DRV_W-1:0]  drive_ff [WHEEL_COUNT];
   val_type                  e1_ff [WHEEL_COUNT];
   val_type                  e2_ff [WHEEL_COUNT];
   logic signed [D1_W-1:0]   d1_ff, d1_in;
   logic signed [D2_W-1:0]   d2_ff, d2_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [DUTY_W-1:0]        res_duty_ff [WHEEL_COUNT];
   logic [WHEEL_COUNT-1:0]   res_dir_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [DUTY_W-1:0]        out_duty_ff [WHEEL_COUNT];
   logic [WHEEL_COUNT-1:0]   out_dir_ff;

   val_type                  e_cur, e1_cur, e2_cur;
   logic signed [DRV_W-1:0]  drive_cur, drive_in;
   logic [GAIN_W-1:0]        mul_gain;
   logic signed [D2_W-1:0]   mul_opnd;
   logic signed [ACC_W-1:0]  biased;
   logic signed [QUO_W-1:0]  quo, lim_pos, lim_neg, clamped;
   logic [DUTY_W-1:0]        mag_in;
   logic                     dir_in;
   logic                     last_wheel;
   logic                     load_out;

   assign pop_ready  = (state_ff == B_IDLE);
   assign last_wheel = (wheel_ff == WHEEL_W'(WHEEL_COUNT - 1));
   assign load_out   = (state_ff == B_DONE) && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      e_cur     = entry_ff[wheel_ff];
      e1_cur    = e1_ff[wheel_ff];
      e2_cur    = e2_ff[wheel_ff];
      drive_cur = drive_ff[wheel_ff];
      d1_in     = D1_W'(e_cur) - D1_W'(e1_cur);
      d2_in     = D2_W'(e_cur) - (D2_W'(e1_cur) <<< 1) + D2_W'(e2_cur);
   end

   // One multiplier, used for the integral, proportional and derivative terms in turn.
   always_comb begin
      case (state_ff)
         B_INT: begin
            mul_gain = cfg.integ_gain;
            mul_opnd = D2_W'(e_cur);
         end
         B_PROP: begin
            mul_gain = cfg.prop_gain;
            mul_opnd = D2_W'(d1_ff);
         end
         default: begin
            mul_gain = cfg.deriv_gain;
            mul_opnd = d2_ff;
         end
      endcase
      prod_in = PROD_W'($signed({1'b0, mul_gain})) * PROD_W'(mul_opnd);
      if (state_ff == B_INT) begin
         acc_in = ACC_W'(drive_cur) <<< FRAC_W;
      end else begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // New drive value: scaled sum truncated toward zero, then clamped to the duty limit.
   always_comb begin
      biased  = acc_ff + $signed({{(ACC_W - FRAC_W){1'b0}}, {FRAC_W{acc_ff[ACC_W-1]}}});
      quo     = biased[ACC_W-1:FRAC_W];
      lim_pos = QUO_W'($signed({1'b0, cfg.duty_limit}));
      lim_neg = -lim_pos;
      if (quo > lim_pos) begin
         clamped = lim_pos;
      end else if (quo < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = quo;
      end
      drive_in = DRV_W'(clamped);
      mag_in   = drive_in[DRV_W-1] ? DUTY_W'(-drive_in) : DUTY_W'(drive_in);
      dir_in   = DIR_FWD[wheel_ff] ^ drive_in[DRV_W-1];
   end

   always_comb begin
      state_in = state_ff;
      wheel_in = wheel_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               state_in = B_INT;
               wheel_in = '0;
            end
         end
         B_INT: begin
            state_in = B_PROP;
         end
         B_PROP: begin
            state_in = B_DERIV;
         end
         B_DERIV: begin
            state_in = B_SUM;
         end
         B_SUM: begin
            state_in = B_UPD;
         end
         B_UPD: begin
            if (last_wheel) begin
               state_in = B_DONE;
            end else begin
               wheel_in = wheel_ff + 1'b1;
               state_in = B_INT;
            end
         end
         B_DONE: begin
            if (load_out) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         wheel_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            drive_ff[i] <= '0;
            e1_ff[i]    <= '0;
            e2_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wheel_ff     <= wheel_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == B_INT) begin
            e2_ff[wheel_ff] <= e1_cur;
            e1_ff[wheel_ff] <= e_cur;
         end
         if (state_ff == B_UPD) begin
            drive_ff[wheel_ff] <= drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && pop_valid) begin
         entry_ff <= pop_data;
      end
      if (state_ff == B_INT) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (state_ff == B_UPD) begin
         res_duty_ff[wheel_ff] <= mag_in;
         res_dir_ff[wheel_ff]  <= dir_in;
      end
      if (load_out) begin
         out_duty_ff <= res_duty_ff;
         out_dir_ff  <= res_dir_ff;
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.duty_0 = out_duty_ff[0];
   assign rsp_ch.duty_1 = out_duty_ff[1];
   assign rsp_ch.duty_2 = out_duty_ff[2];
   assign rsp_ch.duty_3 = out_duty_ff[3];
   assign rsp_ch.dir_0  = out_dir_ff[0];
   assign rsp_ch.dir_1  = out_dir_ff[1];
   assign rsp_ch.dir_2  = out_dir_ff[2];
   assign rsp_ch.dir_3  = out_dir_ff[3];

endmodule

`default_nettype wire

// File: hw/rtl/msp_chk.sv
// Port-level checks on the wheel speed controller and the bind that attaches them.
`default_nettype none

module msp_chk (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [msp_pkg::DUTY_W-1:0] duty_0,
   input wire logic [msp_pkg::DUTY_W-1:0] duty_1,
   input wire logic [msp_pkg::DUTY_W-1:0] duty_2,
   input wire logic [msp_pkg::DUTY_W-1:0] duty_3,
   input wire logic                      dir_0,
   input wire logic                      dir_1,
   input wire logic                      dir_2,
   input wire logic                      dir_3
);
   import msp_pkg::*;

   // Reset empties the output register.
   a_reset_clears_result: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // A stalled result stays valid and keeps its duty values.
   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(duty_0) && $stable(duty_1)
                                  && $stable(duty_2) && $stable(duty_3))
      else $error("stalled result changed");

   // A zero duty means a zero drive value, which shows the forward pin levels.
   a_zero_duty_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (duty_0 != '0 || dir_0) && (duty_1 != '0 || dir_1)
                    && (duty_2 != '0 || !dir_2) && (duty_3 != '0 || !dir_3))
      else $error("zero duty with reverse direction");

endmodule

bind mecanum_wheel_speed_pid msp_chk u_msp_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .duty_0    (rsp_ch.duty_0),
   .duty_1    (rsp_ch.duty_1),
   .duty_2    (rsp_ch.duty_2),
   .duty_3    (rsp_ch.duty_3),
   .dir_0     (rsp_ch.dir_0),
   .dir_1     (rsp_ch.dir_1),
   .dir_2     (rsp_ch.dir_2),
   .dir_3     (rsp_ch.dir_3)
);

`default_nettype wire

// File: tb/sv/msp_checker.sv
// Checker that predicts the wheel duty items from the command items and compares them.
`timescale 1ns / 1ps

module msp_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   msp_req_if                                  req_ch,
   msp_rsp_if                                  rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [msp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [msp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                  mismatches,
   output int                                  pending
);
   import msp_pkg::*;

   typedef struct packed {
      logic [WHEEL_COUNT-1:0][DUTY_W-1:0] duty;
      logic [WHEEL_COUNT-1:0]             dir;
   } wheel_drive_type;

   // Mirror of the configuration registers.
   logic [GAIN_W-1:0] gain_p;
   logic [GAIN_W-1:0] gain_i;
   logic [GAIN_W-1:0] gain_d;
   logic [GAIN_W-1:0] gain_turn;
   logic [DUTY_W-1:0] drive_cap;
   logic              loops_on;

   // Wheel loop state: drive value and the last two errors of each wheel.
   longint drive_level [WHEEL_COUNT];
   longint err_prev    [WHEEL_COUNT];
   longint err_older   [WHEEL_COUNT];

   wheel_drive_type duty_expect [$];

   function automatic longint clip_speed(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // One control tick: kinematics, then the incremental PID of every wheel.
   function automatic wheel_drive_type run_speed_loops(
      input val_type                            cmd_x,
      input val_type                            cmd_y,
      input val_type                            cmd_turn,
      input logic [WHEEL_COUNT-1:0][VAL_W-1:0]  enc
   );
      wheel_drive_type r;
      longint          turn, sum, target, err, step, level, cap;
      turn = longint'(cmd_turn) * longint'(gain_turn);
      cap  = longint'(drive_cap);
      for (int w = 0; w < WHEEL_COUNT; w++) begin
         sum = (longint'(cmd_y) + (VX_NEG[w] ? -longint'(cmd_x) : longint'(cmd_x))) * 65536
             + (TURN_NEG[w] ? -turn : turn);
         // Signed division truncates toward zero, as the kinematics require.
         target = clip_speed(sum / 65536);
         err    = clip_speed(target - longint'($signed(enc[w])));
         step   = longint'(gain_p) * (err - err_prev[w])
                + longint'(gain_i) * err
                + longint'(gain_d) * (err - 2 * err_prev[w] + err_older[w]);
         level  = (drive_level[w] * 256 + step) / 256;
         if (level > cap) level = cap;
         if (level < -cap) level = -cap;
         drive_level[w] = level;
         err_older[w]   = err_prev[w];
         err_prev[w]    = err;
         r.duty[w] = (level < 0) ? DUTY_W'(-level) : DUTY_W'(level);
         r.dir[w]  = (level >= 0) ? DIR_FWD[w] : ~DIR_FWD[w];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      wheel_drive_type want, got;
      if (reset) begin
         gain_p    = CFG_RST.prop_gain;
         gain_i    = CFG_RST.integ_gain;
         gain_d    = CFG_RST.deriv_gain;
         gain_turn = CFG_RST.rotation_gain;
         drive_cap = CFG_RST.duty_limit;
         loops_on  = CFG_RST.run_loops;
         for (int w = 0; w < WHEEL_COUNT; w++) begin
            drive_level[w] = 0;
            err_prev[w]    = 0;
            err_older[w]   = 0;
         end
         duty_expect.delete();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PROP_GAIN:     gain_p    = csr_wdata;
               CSR_INTEG_GAIN:    gain_i    = csr_wdata;
               CSR_DERIV_GAIN:    gain_d    = csr_wdata;
               CSR_ROTATION_GAIN: gain_turn = csr_wdata;
               CSR_DUTY_LIMIT:    drive_cap = csr_wdata[DUTY_W-1:0];
               CSR_RUN_LOOPS:     loops_on  = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.duty = {rsp_ch.duty_3, rsp_ch.duty_2, rsp_ch.duty_1, rsp_ch.duty_0};
            got.dir  = {rsp_ch.dir_3, rsp_ch.dir_2, rsp_ch.dir_1, rsp_ch.dir_0};
            if (duty_expect.size() == 0) begin
               $error("result item arrived with no item expected");
               mismatches++;
            end else begin
               want = duty_expect.pop_front();
               for (int w = 0; w < WHEEL_COUNT; w++) begin
                  if (want.duty[w] != got.duty[w]) begin
                     $error("duty_%0d expected %0d, got %0d", w, want.duty[w], got.duty[w]);
                     mismatches++;
                  end
                  if (want.dir[w] != got.dir[w]) begin
                     $error("dir_%0d expected %0d, got %0d", w, want.dir[w], got.dir[w]);
                     mismatches++;
                  end
               end
            end
         end
         // A disabled block drops the item and leaves the wheel state alone.
         if (req_ch.valid && req_ch.ready && loops_on) begin
            duty_expect.push_back(run_speed_loops(req_ch.vel_x, req_ch.vel_y, req_ch.turn_rate,
               {req_ch.encoder_3, req_ch.encoder_2, req_ch.encoder_1, req_ch.encoder_0}));
         end
      end
      pending = duty_expect.size();
   end

endmodule

// File: tb/sv/testbench.sv
// Top of the testbench: clock, reset, stimulus, receiver and verdict for the wheel controller.
`timescale 1ns / 1ps

module testbench;
   import msp_pkg::*;

   // Spare register indexes; writes to them must leave every register unchanged.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam int PHASES          = 6;
   localparam int TICKS_PER_PHASE = 75;
   // Dropped items are taken by the front end and go no further.
   localparam int DRAIN_CYCLES    = 60;
   localparam int HOLD_CYCLES     = 300;
   localparam int CYCLE_LIMIT     = 200000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int pending;
   int cycle_count = 0;

   // Set when idling stops for the final part of the run.
   bit calm = 1'b0;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit hold_off = 1'b0;

   // Body velocity command that the random part keeps for a run of ticks.
   val_type cmd_x, cmd_y, cmd_turn;

   msp_req_if req_ch ();
   msp_rsp_if rsp_ch ();

   mecanum_wheel_speed_pid i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   msp_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a run that gets stuck ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("mecanum_wheel_speed_pid verification failed");
         $finish;
      end
   end

   // Receiver. It stalls in short random bursts, once holds off for a long stretch so that
   // the queue and output register fill and the block pushes back on its input, and stays
   // ready throughout the final part of the run.
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // Writes one register. Enable is dropped in the following cycle, so back-to-back writes
   // never assign the enable twice in one time step.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [15:0] kp, ki, kd, kturn, cap);
      write_reg(CSR_PROP_GAIN, kp);
      write_reg(CSR_INTEG_GAIN, ki);
      write_reg(CSR_DERIV_GAIN, kd);
      write_reg(CSR_ROTATION_GAIN, kturn);
      write_reg(CSR_DUTY_LIMIT, cap);
      write_reg(CSR_RUN_LOOPS, 16'd1);
   endtask

   // Offers one control tick, maybe after a random gap, and returns at the falling edge after
   // it was taken. Valid stays high there so that the next tick can follow without a bubble.
   task automatic send_tick(input val_type vx, vy, wr, e0, e1, e2, e3);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.vel_x     <= vx;
      req_ch.vel_y     <= vy;
      req_ch.turn_rate <= wr;
      req_ch.encoder_0 <= e0;
      req_ch.encoder_1 <= e1;
      req_ch.encoder_2 <= e2;
      req_ch.encoder_3 <= e3;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Waits until every expected result has come and the block has had time to finish any
   // dropped item, so that registers can be written safely.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Speed values: mostly small ones that keep the loops out of saturation, some full-range
   // values so that every bit toggles, and the corner values.
   function automatic val_type pick_speed();
      case ($urandom_range(0, 9))
         0, 1, 2: return val_type'($urandom_range(0, 65535));
         3: begin
            case ($urandom_range(0, 3))
               0: return -16'sd32768;
               1: return 16'sd32767;
               2: return 16'sd0;
               default: return -16'sd1;
            endcase
         end
         4, 5, 6: return val_type'(int'($urandom_range(0, 6000)) - 3000);
         default: return val_type'(int'($urandom_range(0, 120)) - 60);
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 4096));
      endcase
   endfunction

   // A command is held for a run of ticks, as a real controller would, while the measured
   // wheel speeds move around; the PID state then builds up over many ticks.
   task automatic random_tick();
      if ($urandom_range(0, 7) == 0) begin
         cmd_x    = pick_speed();
         cmd_y    = pick_speed();
         cmd_turn = pick_speed();
      end
      send_tick(cmd_x, cmd_y, cmd_turn, pick_speed(), pick_speed(), pick_speed(), pick_speed());
   endtask

   initial begin
      csr_we           = 1'b0;
      csr_index        = CSR_PROP_GAIN;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.vel_x     = '0;
      req_ch.vel_y     = '0;
      req_ch.turn_rate = '0;
      req_ch.encoder_0 = '0;
      req_ch.encoder_1 = '0;
      req_ch.encoder_2 = '0;
      req_ch.encoder_3 = '0;
      cmd_x            = '0;
      cmd_y            = '0;
      cmd_turn         = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The loops come out of reset disabled, so these ticks are dropped without a result.
      send_tick(16'sd32767, -16'sd32768, 16'sd1000, 16'sd5, -16'sd5, 16'sd7, -16'sd7);
      send_tick(-16'sd32768, 16'sd32767, -16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      settle();
      write_reg(CSR_RUN_LOOPS, 16'd1);

      // Default gains: a zero tick, both saturating corners of target and error, then each
      // axis of the command alone, including a turn so small that it truncates to nothing.
      send_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_tick(16'sd32767, 16'sd32767, 16'sd32767,
                -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_tick(-16'sd32768, -16'sd32768, -16'sd32768,
                16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_tick(16'sd0, 16'sd1000, 16'sd0, 16'sd900, 16'sd1100, 16'sd950, 16'sd1050);
      send_tick(16'sd1000, 16'sd0, 16'sd0, -16'sd900, 16'sd900, -16'sd1100, 16'sd1100);
      send_tick(16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_tick(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      settle();

      // Largest gains and rotation term. The duty limit is written with its unused upper bits
      // set, and the spare indexes are written with values that must change nothing.
      write_reg(CSR_PROP_GAIN, 16'hFFFF);
      write_reg(CSR_INTEG_GAIN, 16'hFFFF);
      write_reg(CSR_DERIV_GAIN, 16'hFFFF);
      write_reg(CSR_ROTATION_GAIN, 16'hFFFF);
      write_reg(CSR_DUTY_LIMIT, 16'hFFFF);
      write_reg(CSR_SPARE_6, 16'h0000);
      write_reg(CSR_SPARE_7, 16'h1234);
      send_tick(16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_tick(16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_tick(16'sd0, 16'sd0, -16'sd3, 16'sd5, -16'sd5, 16'sd5, -16'sd5);
      send_tick(-16'sd32768, 16'sd32767, 16'sd0, 16'sd12, -16'sd12, 16'sd3, -16'sd3);
      settle();

      // Zero duty limit: every drive value is pinned at zero.
      write_reg(CSR_DUTY_LIMIT, 16'd0);
      send_tick(16'sd2000, -16'sd3000, 16'sd500, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
      send_tick(-16'sd2000, 16'sd3000, -16'sd500, -16'sd1, -16'sd2, -16'sd3, -16'sd4);
      settle();

      // Disabling in the middle of the run must hold the wheel state until the next enable.
      configure(CFG_RST.prop_gain, CFG_RST.integ_gain, CFG_RST.deriv_gain,
                CFG_RST.rotation_gain, 16'(CFG_RST.duty_limit));
      write_reg(CSR_RUN_LOOPS, 16'd0);
      send_tick(16'sd500, 16'sd500, 16'sd500, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_tick(-16'sd500, 16'sd100, 16'sd50, 16'sd9, 16'sd9, 16'sd9, 16'sd9);
      settle();
      write_reg(CSR_RUN_LOOPS, 16'd1);
      send_tick(16'sd10, 16'sd20, 16'sd30, 16'sd1, 16'sd2, 16'sd3, 16'sd4);

      // Random part: several register settings, the extremes among them. The last phase
      // runs with no idling on either side.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         calm = (phase == PHASES - 1);
         if ($urandom_range(0, 1) == 1) begin
            // A few dropped ticks while disabled, with the old state kept for later.
            write_reg(CSR_RUN_LOOPS, 16'd0);
            repeat (3) random_tick();
            settle();
         end
         case (phase)
            0: configure(CFG_RST.prop_gain, CFG_RST.integ_gain, CFG_RST.deriv_gain,
                         CFG_RST.rotation_gain, 16'(CFG_RST.duty_limit));
            1: configure(pick_gain(), pick_gain(), pick_gain(), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(1, 16383)));
            2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16383);
            3: configure(16'd0, 16'd256, 16'hFFFF, 16'd1, 16'd1);
            4: configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)));
            default: configure(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 512)),
                               16'($urandom_range(0, 256)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(100, 16383)));
         endcase
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if (phase == 1 && n == 20) hold_off = 1'b1;
            random_tick();
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("mecanum_wheel_speed_pid verification clean");
      end else begin
         $display("mecanum_wheel_speed_pid verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/msp_pkg.sv
hw/rtl/msp_if.sv
hw/rtl/msp_front.sv
hw/rtl/msp_fifo.sv
hw/rtl/msp_back.sv
hw/rtl/mecanum_wheel_speed_pid.sv
hw/rtl/msp_chk.sv
tb/sv/msp_checker.sv
tb/sv/testbench.sv
